[sv/mbb_pkg.sv]
// shared types and constants of the masked box blur
`timescale 1ns / 1ps
package mbb_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int QUOT_STEPS = 8;
  localparam int STEP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BGND   = 2'd3;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [2:0]  RADIUS_RST = 3'd1;
  localparam logic [7:0]  BGND_RST   = 8'd0;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic flag;
    rgb_t rgb;
  } entry_t;

endpackage

[sv/mbb_store.sv]
// line store memory, one write and one registered read port
`timescale 1ns / 1ps
module mbb_store #(
  parameter int ADDR_W = 14
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  mbb_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output mbb_pkg::entry_t     rdata_o
);

  mbb_pkg::entry_t mem [2**ADDR_W];
  mbb_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mbb_div.sv]
// iterative divider, one quotient bit per cycle, quotient below 256
`timescale 1ns / 1ps
module mbb_div #(
  parameter int SUM_BITS = 18,
  parameter int CNT_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [SUM_BITS-1:0]          dividend_i,
  input  logic [CNT_BITS-1:0]          divisor_i,
  output logic                         done_o,
  output logic [mbb_pkg::PIX_W-1:0]    quot_o
);

  logic                              busy_q;
  logic [mbb_pkg::STEP_W-1:0]        step_q;
  logic [SUM_BITS-1:0]               rem_q;
  logic [mbb_pkg::PIX_W-1:0]         quot_q;
  logic [SUM_BITS-1:0]               trial;

  assign trial  = SUM_BITS'(divisor_i) << step_q;
  assign done_o = busy_q && (step_q == '0);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      quot_q <= '0;
      step_q <= mbb_pkg::STEP_W'(mbb_pkg::QUOT_STEPS - 1);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q          <= rem_q - trial;
        quot_q[step_q] <= 1'b1;
      end
      step_q <= step_q - 1'b1;
    end
  end

endmodule

[sv/masked_box_blur_rgb_unit.sv]
// masked box blur over an rgb raster stream with line store
// a copied pixel passes the check, centre and result states into the output register,
//   a blurred pixel also the scan, drain, start and divide states; result waits on out_stall
// the input stalls outside idle, so a new item waits for the last; a due result is paced
//   by the window scan through the single line store read port and the 8 step divider
// reset clears counters and the output valid flag, loads register defaults, not the store
`timescale 1ns / 1ps
module masked_box_blur_rgb_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [mbb_pkg::PIX_W-1:0]         red_in_i,
  input  logic [mbb_pkg::PIX_W-1:0]         green_in_i,
  input  logic [mbb_pkg::PIX_W-1:0]         blue_in_i,
  input  logic [mbb_pkg::PIX_W-1:0]         mask_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mbb_pkg::PIX_W-1:0]         red_out_o,
  output logic [mbb_pkg::PIX_W-1:0]         green_out_o,
  output logic [mbb_pkg::PIX_W-1:0]         blue_out_o,
  output logic                              frame_end_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mbb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WW       = COL_BITS + 1;
  localparam int RW       = mbb_pkg::ROW_W;
  localparam int LW       = WW + RW;
  localparam int RB       = $clog2(2 * MAX_RADIUS + 2);
  localparam int RADW     = $clog2(MAX_RADIUS + 1);
  localparam int CNT_BITS = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_BITS = CNT_BITS + mbb_pkg::PIX_W;
  localparam int ADDR_W   = RB + COL_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CENTRE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_START  = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0]          state_q;
  logic [10:0]         cfg_width_q;
  logic [12:0]         cfg_height_q;
  logic [2:0]          cfg_radius_q;
  logic [7:0]          cfg_bgnd_q;

  logic [RW-1:0]       in_row_q, out_row_q, y_q, y1_q;
  logic [COL_BITS-1:0] in_col_q, out_col_q, x_q, x0_q, x1_q;
  logic [LW-1:0]       in_lin_q, out_lin_q, total_q, delay_q;
  logic                pend_q, blur_q;
  logic [SUM_BITS-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [CNT_BITS-1:0] cnt_q;
  mbb_pkg::rgb_t       copy_q;

  logic                out_valid_q, frame_end_q;
  mbb_pkg::rgb_t       out_q;

  logic [WW-1:0]       w_eff, wm1, in_col_inc, col_hi_sum, out_col_inc;
  logic [RW-1:0]       h_eff, row_lo;
  logic [RW:0]         row_hi_sum;
  logic [RADW-1:0]     r_eff;
  logic [LW-1:0]       total_d, delay_d;
  logic [LW:0]         need;
  logic                due, in_acc, pix_wr, out_free, last_out;
  logic                store_re;
  logic [ADDR_W-1:0]   store_raddr;
  mbb_pkg::entry_t     wentry, rentry;
  logic                div_start;
  logic [2:0]          div_done;
  logic [mbb_pkg::PIX_W-1:0] quot_r, quot_g, quot_b;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(cfg_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_q);
    end
    h_eff = (cfg_height_q == '0) ? RW'(1) : cfg_height_q;
    if (int'(cfg_radius_q) > MAX_RADIUS) begin
      r_eff = RADW'(MAX_RADIUS);
    end else begin
      r_eff = RADW'(cfg_radius_q);
    end
  end

  assign wm1         = w_eff - WW'(1);
  assign total_d     = LW'(w_eff) * LW'(h_eff);
  assign delay_d     = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
  assign need        = {1'b0, out_lin_q} + {1'b0, delay_q} + (LW + 1)'(1);
  assign due         = (in_lin_q == total_q) || ({1'b0, in_lin_q} >= need);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pix_wr      = in_acc && (action_i == mbb_pkg::ACT_PIXEL) && (in_row_q < h_eff);
  assign in_col_inc  = {1'b0, in_col_q} + WW'(1);
  assign out_col_inc = {1'b0, out_col_q} + WW'(1);
  assign col_hi_sum  = {1'b0, out_col_q} + WW'(r_eff);
  assign row_hi_sum  = {1'b0, out_row_q} + (RW + 1)'(r_eff);
  assign row_lo      = (out_row_q >= RW'(r_eff)) ? out_row_q - RW'(r_eff) : '0;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_out    = (out_lin_q + LW'(1)) == total_q;
  assign div_start   = (state_q == S_START);

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign wentry.flag      = (mask_in_i == cfg_bgnd_q);
  assign wentry.rgb.red   = red_in_i;
  assign wentry.rgb.green = green_in_i;
  assign wentry.rgb.blue  = blue_in_i;

  always_comb begin
    store_re    = 1'b0;
    store_raddr = {out_row_q[RB-1:0], out_col_q};
    if (state_q == S_CHECK) begin
      store_re = due;
    end else if (state_q == S_SCAN) begin
      store_re    = 1'b1;
      store_raddr = {y_q[RB-1:0], x_q};
    end
  end

  mbb_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pix_wr),
    .waddr_i ({in_row_q[RB-1:0], in_col_q}),
    .wdata_i (wentry),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (rentry)
  );

  mbb_div #(.SUM_BITS(SUM_BITS), .CNT_BITS(CNT_BITS)) u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start), .dividend_i (sum_r_q),
    .divisor_i (cnt_q), .done_o (div_done[0]), .quot_o (quot_r)
  );

  mbb_div #(.SUM_BITS(SUM_BITS), .CNT_BITS(CNT_BITS)) u_div_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start), .dividend_i (sum_g_q),
    .divisor_i (cnt_q), .done_o (div_done[1]), .quot_o (quot_g)
  );

  mbb_div #(.SUM_BITS(SUM_BITS), .CNT_BITS(CNT_BITS)) u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start), .dividend_i (sum_b_q),
    .divisor_i (cnt_q), .done_o (div_done[2]), .quot_o (quot_b)
  );

  // control, registers and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_width_q  <= mbb_pkg::WIDTH_RST;
      cfg_height_q <= mbb_pkg::HEIGHT_RST;
      cfg_radius_q <= mbb_pkg::RADIUS_RST;
      cfg_bgnd_q   <= mbb_pkg::BGND_RST;
      in_row_q     <= '0;
      in_col_q     <= '0;
      in_lin_q     <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_lin_q    <= '0;
      total_q      <= '0;
      delay_q      <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_q <= (state_q == S_SCAN);
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            total_q <= total_d;
            delay_q <= delay_d;
            state_q <= S_CHECK;
            if (pix_wr) begin
              in_lin_q <= in_lin_q + LW'(1);
              if (in_col_inc >= w_eff) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + RW'(1);
              end else begin
                in_col_q <= in_col_inc[COL_BITS-1:0];
              end
            end
          end
        end
        S_CHECK: begin
          state_q <= due ? S_CENTRE : S_IDLE;
        end
        S_CENTRE: begin
          state_q <= rentry.flag ? S_SCAN : S_RESULT;
        end
        S_SCAN: begin
          if (x_q == x1_q && y_q == y1_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_START;
        end
        S_START: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (&div_done) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (last_out) begin
              in_row_q  <= '0;
              in_col_q  <= '0;
              in_lin_q  <= '0;
              out_row_q <= '0;
              out_col_q <= '0;
              out_lin_q <= '0;
            end else begin
              out_lin_q <= out_lin_q + LW'(1);
              if (out_col_inc >= w_eff) begin
                out_col_q <= '0;
                out_row_q <= out_row_q + RW'(1);
              end else begin
                out_col_q <= out_col_inc[COL_BITS-1:0];
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mbb_pkg::CFG_WIDTH:  cfg_width_q  <= cfg_data_i[10:0];
          mbb_pkg::CFG_HEIGHT: cfg_height_q <= cfg_data_i[12:0];
          mbb_pkg::CFG_RADIUS: cfg_radius_q <= cfg_data_i[2:0];
          mbb_pkg::CFG_BGND:   cfg_bgnd_q   <= cfg_data_i[7:0];
          default: ;
        endcase
        in_row_q  <= '0;
        in_col_q  <= '0;
        in_lin_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        out_lin_q <= '0;
      end
    end
  end

  // window scan and accumulation
  always_ff @(posedge clk_i) begin
    if (state_q == S_CENTRE) begin
      blur_q  <= rentry.flag;
      copy_q  <= rentry.rgb;
      y_q     <= row_lo;
      y1_q    <= (row_hi_sum >= {1'b0, h_eff}) ? h_eff - RW'(1) : row_hi_sum[RW-1:0];
      x_q     <= (out_col_q >= COL_BITS'(r_eff)) ? out_col_q - COL_BITS'(r_eff) : '0;
      x0_q    <= (out_col_q >= COL_BITS'(r_eff)) ? out_col_q - COL_BITS'(r_eff) : '0;
      x1_q    <= (col_hi_sum >= w_eff) ? wm1[COL_BITS-1:0] : col_hi_sum[COL_BITS-1:0];
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (state_q == S_SCAN) begin
        if (x_q == x1_q) begin
          x_q <= x0_q;
          y_q <= y_q + RW'(1);
        end else begin
          x_q <= x_q + COL_BITS'(1);
        end
      end
      if (pend_q) begin
        sum_r_q <= sum_r_q + SUM_BITS'(rentry.rgb.red);
        sum_g_q <= sum_g_q + SUM_BITS'(rentry.rgb.green);
        sum_b_q <= sum_b_q + SUM_BITS'(rentry.rgb.blue);
        cnt_q   <= cnt_q + CNT_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_RESULT && out_free) begin
      frame_end_q <= last_out;
      if (blur_q) begin
        out_q.red   <= quot_r;
        out_q.green <= quot_g;
        out_q.blue  <= quot_b;
      end else begin
        out_q <= copy_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q.red;
  assign green_out_o = out_q.green;
  assign blue_out_o  = out_q.blue;
  assign frame_end_o = frame_end_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START) |-> (cnt_q != '0))
    else $error("window count zero at divide");

  a_out_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (out_lin_q < total_q) && (in_lin_q <= total_q))
    else $error("position counters beyond frame");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && out_free) |=> out_valid_q && (state_q == S_IDLE))
    else $error("result not loaded into output register");

endmodule
